### rtl/pme_pkg.sv
package pme_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int FACT_W     = 24;
	localparam int PROD_W     = DATA_W + FACT_W + 1;
	localparam int CFG_ADDR_W = 3;

	localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_GRAVITY   = 3'd0,
		CFG_INV_MASS  = 3'd1,
		CFG_TIME_STEP = 3'd2,
		CFG_GND_FRIC  = 3'd3,
		CFG_AIR_FRIC  = 3'd4,
		CFG_MAX_SPD_X = 3'd5,
		CFG_MAX_SPD_Y = 3'd6,
		CFG_ELASTIC   = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_NEG  = 2'd1,
		DIR_POS  = 2'd2
	} dir_t;

	// one multiply per step, in frame order
	typedef enum logic [3:0] {
		STEP_BNC_X = 4'd0,
		STEP_BNC_Y = 4'd1,
		STEP_GRAV  = 4'd2,
		STEP_AX_IM = 4'd3,
		STEP_AX_TS = 4'd4,
		STEP_AY_IM = 4'd5,
		STEP_AY_TS = 4'd6,
		STEP_FR_X  = 4'd7,
		STEP_FR_Y  = 4'd8,
		STEP_DSP_X = 4'd9,
		STEP_DSP_Y = 4'd10
	} step_t;

	localparam step_t STEP_LAST = STEP_DSP_Y;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_MUL  = 2'd1,
		ST_WB   = 2'd2,
		ST_FIN  = 2'd3
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] force_x;
		logic signed [DATA_W-1:0] force_y;
		logic                     grounded;
		logic                     bounce_x;
		logic                     bounce_y;
		logic                     clear_accel;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] disp_x;
		logic signed [DATA_W-1:0] disp_y;
		logic [1:0]               dir_lr;
		logic [1:0]               dir_ud;
	} out_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gravity;
		logic [FACT_W-1:0]        inv_mass;
		logic [16:0]              time_step;
		logic [16:0]              gnd_scale;
		logic [16:0]              air_scale;
		logic [30:0]              max_speed_x;
		logic [30:0]              max_speed_y;
		logic [16:0]              elasticity;
	} cfg_t;

	typedef struct packed {
		logic  load;
		logic  mul;
		logic  wb;
		logic  fin;
		step_t step;
	} cmd_t;

	// floor shift of a product, saturated to 32 bits
	function automatic logic signed [DATA_W-1:0] mulq_fix(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] sh;
		logic signed [DATA_W-1:0] r;
		sh = p >>> FRAC_BITS;
		if ((&sh[PROD_W-1:DATA_W-1]) || !(|sh[PROD_W-1:DATA_W-1]))
			r = sh[DATA_W-1:0];
		else if (sh[PROD_W-1])
			r = S_MIN;
		else
			r = S_MAX;
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
	                                                     input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] s;
		logic signed [DATA_W-1:0] r;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1])
			r = s[DATA_W] ? S_MIN : S_MAX;
		else
			r = s[DATA_W-1:0];
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] a);
		logic signed [DATA_W-1:0] r;
		if (a == S_MIN)
			r = S_MAX;
		else
			r = -a;
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] clamp_mag(input logic signed [DATA_W-1:0] v,
	                                                       input logic [DATA_W-2:0] m);
		logic signed [DATA_W:0] vv;
		logic signed [DATA_W:0] mm;
		logic signed [DATA_W-1:0] r;
		vv = {v[DATA_W-1], v};
		mm = {2'b00, m};
		if (vv > mm)
			r = mm[DATA_W-1:0];
		else if (vv < -mm)
			r = neg_sat(mm[DATA_W-1:0]);
		else
			r = v;
		return r;
	endfunction

	function automatic dir_t dir_of(input logic signed [DATA_W-1:0] v);
		dir_t d;
		if (v[DATA_W-1])
			d = DIR_NEG;
		else if (|v)
			d = DIR_POS;
		else
			d = DIR_NONE;
		return d;
	endfunction

endpackage

### rtl/pme_cfg.sv
module pme_cfg
	import pme_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [DATA_W-1:0]     cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity     <= '0;
			cfg_q.inv_mass    <= FACT_W'(1 << FRAC_BITS);
			cfg_q.time_step   <= 17'd65536;
			cfg_q.gnd_scale   <= 17'd65536;
			cfg_q.air_scale   <= 17'd65536;
			cfg_q.max_speed_x <= '1;
			cfg_q.max_speed_y <= '1;
			cfg_q.elasticity  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_GRAVITY:   cfg_q.gravity     <= cfg_wdata;
				CFG_INV_MASS:  cfg_q.inv_mass    <= cfg_wdata[FACT_W-1:0];
				CFG_TIME_STEP: cfg_q.time_step   <= cfg_wdata[16:0];
				CFG_GND_FRIC:  cfg_q.gnd_scale   <= cfg_wdata[16:0];
				CFG_AIR_FRIC:  cfg_q.air_scale   <= cfg_wdata[16:0];
				CFG_MAX_SPD_X: cfg_q.max_speed_x <= cfg_wdata[30:0];
				CFG_MAX_SPD_Y: cfg_q.max_speed_y <= cfg_wdata[30:0];
				CFG_ELASTIC:   cfg_q.elasticity  <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/pme_ctrl.sv
module pme_ctrl
	import pme_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	step_t  step_q;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_WB;
			ST_WB:   state_d = (step_q == STEP_LAST) ? ST_FIN : ST_MUL;
			ST_FIN:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.mul  = (state_q == ST_MUL);
		cmd.wb   = (state_q == ST_WB);
		cmd.fin  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
		cmd.step = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_BNC_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				step_q <= STEP_BNC_X;
			else if (cmd.wb && step_q != STEP_LAST)
				step_q <= step_t'(step_q + 4'd1);
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/pme_dp.sv
module pme_dp
	import pme_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  cfg_t cfg,
	input  in_t  in_data,
	output out_t out_data
);

	logic signed [DATA_W-1:0] ax_q, ay_q, sx_q, sy_q, px_q, py_q;
	logic signed [DATA_W-1:0] tmp_q, dx_q, dy_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     grounded_q, bounce_x_q, bounce_y_q, clear_q;
	out_t                     out_q;

	logic signed [DATA_W-1:0] op_a;
	logic [FACT_W-1:0]        op_b;
	logic [16:0]              fric;
	logic signed [DATA_W-1:0] m;

	assign fric = grounded_q ? cfg.gnd_scale : cfg.air_scale;
	assign m    = mulq_fix(prod_q);

	always_comb begin
		case (cmd.step)
			STEP_BNC_X: begin op_a = sx_q;        op_b = FACT_W'(cfg.elasticity); end
			STEP_BNC_Y: begin op_a = sy_q;        op_b = FACT_W'(cfg.elasticity); end
			STEP_GRAV:  begin op_a = cfg.gravity; op_b = FACT_W'(cfg.time_step);  end
			STEP_AX_IM: begin op_a = ax_q;        op_b = cfg.inv_mass;            end
			STEP_AX_TS: begin op_a = tmp_q;       op_b = FACT_W'(cfg.time_step);  end
			STEP_AY_IM: begin op_a = ay_q;        op_b = cfg.inv_mass;            end
			STEP_AY_TS: begin op_a = tmp_q;       op_b = FACT_W'(cfg.time_step);  end
			STEP_FR_X:  begin op_a = sx_q;        op_b = FACT_W'(fric);           end
			STEP_FR_Y:  begin op_a = sy_q;        op_b = FACT_W'(fric);           end
			STEP_DSP_X: begin op_a = sx_q;        op_b = FACT_W'(cfg.time_step);  end
			STEP_DSP_Y: begin op_a = sy_q;        op_b = FACT_W'(cfg.time_step);  end
			default:    begin op_a = '0;          op_b = '0;                      end
		endcase
	end

	// shared 32x25 multiplier, registered
	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= op_a * $signed({1'b0, op_b});
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			grounded_q <= in_data.grounded;
			bounce_x_q <= in_data.bounce_x;
			bounce_y_q <= in_data.bounce_y;
			clear_q    <= in_data.clear_accel;
		end
		if (cmd.wb) begin
			case (cmd.step)
				STEP_AX_IM, STEP_AY_IM: tmp_q <= m;
				STEP_DSP_X:             dx_q  <= m;
				STEP_DSP_Y:             dy_q  <= m;
				default: ;
			endcase
		end
		if (cmd.fin) begin
			out_q.pos_x  <= px_q;
			out_q.pos_y  <= py_q;
			out_q.vel_x  <= sx_q;
			out_q.vel_y  <= sy_q;
			out_q.disp_x <= dx_q;
			out_q.disp_y <= dy_q;
			out_q.dir_lr <= dir_of(sx_q);
			out_q.dir_ud <= dir_of(sy_q);
		end
	end

	// body state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			px_q <= '0;
			py_q <= '0;
		end else if (cmd.load) begin
			ax_q <= sat_add(ax_q, in_data.force_x);
			ay_q <= sat_add(ay_q, in_data.force_y);
		end else if (cmd.wb) begin
			case (cmd.step)
				STEP_BNC_X: if (bounce_x_q) begin
					ax_q <= '0;
					sx_q <= neg_sat(m);
				end
				STEP_BNC_Y: if (bounce_y_q) begin
					ay_q <= '0;
					sy_q <= neg_sat(m);
				end
				STEP_GRAV:  ay_q <= sat_add(ay_q, m);
				STEP_AX_TS: sx_q <= sat_add(sx_q, m);
				STEP_AY_TS: sy_q <= sat_add(sy_q, m);
				STEP_FR_X:  sx_q <= clamp_mag(m, cfg.max_speed_x);
				STEP_FR_Y:  sy_q <= clamp_mag(m, cfg.max_speed_y);
				STEP_DSP_X: px_q <= sat_add(px_q, m);
				STEP_DSP_Y: py_q <= sat_add(py_q, m);
				default: ;
			endcase
		end else if (cmd.fin && clear_q) begin
			ax_q <= '0;
			ay_q <= '0;
		end
	end

	assign out_data = out_q;

endmodule

### rtl/point_mass_euler_integrator.sv
// Point-mass integrator: one 2-D body, semi-implicit Euler, Q16.16 throughout.
// Input channel (in_valid/in_ready/in_data): one transaction is one frame,
// carrying force, grounded, bounce and clear flags.
// Output channel (out_valid/out_ready/out_data): one transaction per frame
// with new position, velocity, displacement and direction codes.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle,
// indices as in cfg_idx_t; write only while no frame is in flight.
// Sequence: after a frame is accepted, the force add happens on the accepting
// edge, then eleven multiply/write-back pairs run on the single shared 32x25
// multiplier, then the output register is loaded and the result offered.
// A new frame is taken only in idle, once the previous frame's sequence is
// through; in_ready is low from acceptance until then.
// A new frame is taken while a result still waits in the output register;
// if the receiver stalls, the next frame parks in the final step until the
// register frees up, and in_ready stays low meanwhile.
// Reset clears acceleration, velocity and position to zero and loads the
// configuration defaults (unit mass, unit dt, no friction loss, no clamp).
module point_mass_euler_integrator
	import pme_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [DATA_W-1:0]     cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data
);

	cfg_t cfg;
	cmd_t cmd;

	pme_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sequencer: steps the shared multiplier through the frame
	pme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// body state, multiplier and output register
	pme_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

### rtl/pme_checker.sv
module pme_checker
	import pme_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input out_t                  out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second frame taken during a frame");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result offered too soon after a frame");

endmodule

bind point_mass_euler_integrator pme_checker u_pme_checker (.*);

### bench/tb_point_mass_euler_integrator.sv
module tb_point_mass_euler_integrator;
	import pme_pkg::*;

	// Run guard: the slowest correct run (about 1200 frames, each taking the block's
	// full sequence plus the longest sender gap and receiver stall) stays under CYCLE_LIMIT.
	localparam int     CYCLE_LIMIT  = 1000000;
	// Margin waited after the last result, longer than a frame takes from acceptance
	// to result, before touching the registers or ending the run.
	localparam int     DRAIN_CYCLES = 40;
	localparam int     REPORT_LIMIT = 10;
	localparam longint Q_MAX        = 64'sd2147483647;
	localparam longint Q_MIN        = -64'sd2147483648;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_GRAVITY;
	logic [DATA_W-1:0]     cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_t                   in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;

	// Body state and register copy used for prediction
	cfg_t   body_cfg;
	longint acc_x, acc_y, vel_x, vel_y, pos_x, pos_y;

	out_t frame_results_due[$];
	int   mismatch_count = 0;
	int   results_seen   = 0;
	int   cycle_count    = 0;
	int   stall_left     = 0;
	bit   calm           = 1'b0;	// no gaps on either side while set

	point_mass_euler_integrator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	function automatic longint clip32(input longint v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v;
	endfunction

	// fixed-point product: floor shift by the fraction width, then saturate
	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return clip32(p >>> FRAC_BITS);
	endfunction

	function automatic longint clamp_speed(input longint v, input longint m);
		if (v > m)
			return m;
		if (v < -m)
			return -m;
		return v;
	endfunction

	function automatic dir_t heading(input longint v);
		if (v > 0)
			return DIR_POS;
		if (v < 0)
			return DIR_NEG;
		return DIR_NONE;
	endfunction

	task automatic reset_predictor();
		body_cfg.gravity     = '0;
		body_cfg.inv_mass    = 24'd65536;
		body_cfg.time_step   = 17'd65536;
		body_cfg.gnd_scale   = 17'd65536;
		body_cfg.air_scale   = 17'd65536;
		body_cfg.max_speed_x = 31'h7FFF_FFFF;
		body_cfg.max_speed_y = 31'h7FFF_FFFF;
		body_cfg.elasticity  = '0;
		acc_x = 0;
		acc_y = 0;
		vel_x = 0;
		vel_y = 0;
		pos_x = 0;
		pos_y = 0;
	endtask

	// One frame: force, bounce, gravity, velocity, position, then accel clear.
	function automatic out_t integrate_frame(input in_t f);
		longint fric, dt, im, e, dx, dy;
		out_t   r;
		fric = f.grounded ? longint'(body_cfg.gnd_scale) : longint'(body_cfg.air_scale);
		dt   = longint'(body_cfg.time_step);
		im   = longint'(body_cfg.inv_mass);
		e    = longint'(body_cfg.elasticity);

		acc_x = clip32(acc_x + longint'(f.force_x));
		acc_y = clip32(acc_y + longint'(f.force_y));

		// a bounce throws away this frame's force on that axis
		if (f.bounce_x) begin
			acc_x = 0;
			vel_x = clip32(-fx_mul(vel_x, e));
		end
		if (f.bounce_y) begin
			acc_y = 0;
			vel_y = clip32(-fx_mul(vel_y, e));
		end

		acc_y = clip32(acc_y + fx_mul(longint'(body_cfg.gravity), dt));

		vel_x = clip32(vel_x + fx_mul(fx_mul(acc_x, im), dt));
		vel_y = clip32(vel_y + fx_mul(fx_mul(acc_y, im), dt));
		vel_x = clamp_speed(fx_mul(vel_x, fric), longint'(body_cfg.max_speed_x));
		vel_y = clamp_speed(fx_mul(vel_y, fric), longint'(body_cfg.max_speed_y));

		dx    = fx_mul(vel_x, dt);
		dy    = fx_mul(vel_y, dt);
		pos_x = clip32(pos_x + dx);
		pos_y = clip32(pos_y + dy);

		if (f.clear_accel) begin
			acc_x = 0;
			acc_y = 0;
		end

		r.pos_x  = 32'(pos_x);
		r.pos_y  = 32'(pos_y);
		r.vel_x  = 32'(vel_x);
		r.vel_y  = 32'(vel_y);
		r.disp_x = 32'(dx);
		r.disp_y = 32'(dy);
		r.dir_lr = heading(vel_x);
		r.dir_ud = heading(vel_y);
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// idle length: mostly a few cycles, now and then a long one
	function automatic int stall_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_t make_frame(input logic [31:0] fx, input logic [31:0] fy,
	                                   input bit gnd, input bit bx, input bit by,
	                                   input bit clr);
		in_t f;
		f.force_x     = fx;
		f.force_y     = fy;
		f.grounded    = gnd;
		f.bounce_x    = bx;
		f.bounce_y    = by;
		f.clear_accel = clr;
		return f;
	endfunction

	// small forces dominate so that the body stays away from the rails most of the time
	function automatic logic [31:0] random_force();
		int unsigned r;
		logic [31:0] mag;
		r = $urandom_range(0, 99);
		if (r < 55)
			mag = $urandom_range(0, 32'h0003_FFFF);
		else if (r < 80)
			mag = $urandom_range(0, 32'h00FF_FFFF);
		else if (r < 93)
			return $urandom();
		else begin
			case ($urandom_range(0, 3))
				0: return S_MAX;
				1: return S_MIN;
				2: return 32'hFFFF_FFFF;
				default: return 32'h0;
			endcase
		end
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic in_t random_frame();
		return make_frame(random_force(), random_force(),
		                  1'($urandom_range(0, 1)),
		                  $urandom_range(0, 99) < 15,
		                  $urandom_range(0, 99) < 20,
		                  $urandom_range(0, 99) < 15);
	endfunction

	function automatic logic [16:0] random_factor();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 17'd65536;
		if (r < 85)
			return 17'($urandom_range(32'h0000_C000, 32'h0001_0000));
		return 17'($urandom_range(0, 32'h0001_0000));
	endfunction

	function automatic logic [30:0] random_limit();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 31'h7FFF_FFFF;
		if (r < 80)
			return 31'($urandom_range(0, 32'h0040_0000));
		return 31'($urandom_range(0, 32'h7FFF_FFFF));
	endfunction

	function automatic cfg_t random_setup();
		cfg_t        c;
		logic [31:0] g;
		if ($urandom_range(0, 3) == 0)
			c.gravity = $urandom();
		else begin
			g         = $urandom_range(0, 32'h0002_0000);
			c.gravity = $urandom_range(0, 1) ? -g : g;
		end
		if ($urandom_range(0, 3) != 0)
			c.inv_mass = 24'($urandom_range(1, 32'h0002_0000));
		else
			c.inv_mass = 24'($urandom_range(1, 32'h00FF_FFFF));
		c.time_step   = ($urandom_range(0, 3) == 0) ? 17'd65536
		                                            : 17'($urandom_range(0, 65536));
		c.gnd_scale   = random_factor();
		c.air_scale   = random_factor();
		c.max_speed_x = random_limit();
		c.max_speed_y = random_limit();
		c.elasticity  = 17'($urandom_range(0, 65536));
		return c;
	endfunction

	// ---------------------------------------------------------------- bus tasks

	// one register write; the enable is left high for a following write
	task automatic set_reg(input cfg_idx_t idx, input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			CFG_GRAVITY:   body_cfg.gravity     = v;
			CFG_INV_MASS:  body_cfg.inv_mass    = v[FACT_W-1:0];
			CFG_TIME_STEP: body_cfg.time_step   = v[16:0];
			CFG_GND_FRIC:  body_cfg.gnd_scale   = v[16:0];
			CFG_AIR_FRIC:  body_cfg.air_scale   = v[16:0];
			CFG_MAX_SPD_X: body_cfg.max_speed_x = v[30:0];
			CFG_MAX_SPD_Y: body_cfg.max_speed_y = v[30:0];
			CFG_ELASTIC:   body_cfg.elasticity  = v[16:0];
			default: ;
		endcase
	endtask

	// writes every register; only called with the block idle
	task automatic apply_config(input cfg_t c);
		set_reg(CFG_GRAVITY,   c.gravity);
		set_reg(CFG_INV_MASS,  32'(c.inv_mass));
		set_reg(CFG_TIME_STEP, 32'(c.time_step));
		set_reg(CFG_GND_FRIC,  32'(c.gnd_scale));
		set_reg(CFG_AIR_FRIC,  32'(c.air_scale));
		set_reg(CFG_MAX_SPD_X, 32'(c.max_speed_x));
		set_reg(CFG_MAX_SPD_Y, 32'(c.max_speed_y));
		set_reg(CFG_ELASTIC,   32'(c.elasticity));
		cfg_we <= 1'b0;
	endtask

	// Offers one frame and holds it until the transaction completes. Valid is
	// only dropped ahead of a gap, so back-to-back frames never see it toggle.
	task automatic send_frame(input in_t f);
		int gap;
		gap = (calm || $urandom_range(0, 99) < 55) ? 0 : stall_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= f;
		do @(posedge clk); while (in_ready !== 1'b1);
		frame_results_due.push_back(integrate_frame(f));
	endtask

	// wait until every outstanding frame has reported, plus margin
	task automatic drain();
		in_valid <= 1'b0;
		while (frame_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- result side

	// receiver back-pressure: random stalls, none while calm
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 30) begin
			stall_left <= stall_len() - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
		end
	endtask

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		out_t due;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (frame_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result %0d: nothing expected, got %h", results_seen, out_data);
			end else begin
				due = frame_results_due.pop_front();
				check_field("pos_x",  due.pos_x,  out_data.pos_x);
				check_field("pos_y",  due.pos_y,  out_data.pos_y);
				check_field("vel_x",  due.vel_x,  out_data.vel_x);
				check_field("vel_y",  due.vel_y,  out_data.vel_y);
				check_field("disp_x", due.disp_x, out_data.disp_x);
				check_field("disp_y", due.disp_y, out_data.disp_y);
				check_field("dir_lr", 32'(due.dir_lr), 32'(out_data.dir_lr));
				check_field("dir_ud", 32'(due.dir_ud), 32'(out_data.dir_ud));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("point_mass_euler_integrator test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Reset defaults: unit mass and dt, no friction loss, no clamp, dead bounce.
	// Full-scale forces drive acceleration, velocity and position into saturation.
	task automatic test_reset_state();
		send_frame(make_frame(32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0));
		send_frame(make_frame(S_MAX, S_MIN, 1, 0, 0, 0));
		send_frame(make_frame(S_MAX, S_MIN, 0, 0, 0, 0));
		send_frame(make_frame(32'h0, 32'h0, 0, 1, 1, 0));	// elasticity 0 kills velocity
		send_frame(make_frame(32'hFFFF_FFFF, 32'h0000_0001, 1, 0, 0, 1));
		send_frame(make_frame(32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0));
	endtask

	// Bounces with full retention and friction below one; a bounce together
	// with a force must drop that force.
	task automatic test_bounce();
		cfg_t c;
		drain();
		c.gravity     = 32'h0000_9CCC;
		c.inv_mass    = 24'h01_0000;
		c.time_step   = 17'h0_4000;
		c.gnd_scale   = 17'h0_F000;
		c.air_scale   = 17'h0_FF00;
		c.max_speed_x = 31'h7FFF_FFFF;
		c.max_speed_y = 31'h7FFF_FFFF;
		c.elasticity  = 17'h1_0000;
		apply_config(c);
		send_frame(make_frame(32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 0));
		send_frame(make_frame(32'h0000_0000, 32'h0000_0000, 0, 1, 0, 0));
		send_frame(make_frame(32'h0000_0000, 32'h0000_0000, 1, 0, 1, 0));
		send_frame(make_frame(32'hFFF0_0000, 32'h0010_0000, 1, 1, 1, 0));
		send_frame(make_frame(32'h0001_8000, 32'hFFFE_8000, 0, 0, 0, 1));
		send_frame(make_frame(32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0));
		send_frame(make_frame(32'h7000_0000, 32'h9000_0000, 0, 1, 1, 1));
	endtask

	// Zero inverse mass, zero speed limit, zero friction; then every factor
	// above one with the largest mass reciprocal, so products saturate.
	task automatic test_edge_factors();
		cfg_t c;
		drain();
		c.gravity     = S_MIN;
		c.inv_mass    = '0;
		c.time_step   = 17'h1_0000;
		c.gnd_scale   = '0;
		c.air_scale   = 17'h1_0000;
		c.max_speed_x = '0;
		c.max_speed_y = 31'h0001_0000;
		c.elasticity  = 17'h0_8000;
		apply_config(c);
		send_frame(make_frame(S_MAX, S_MAX, 0, 0, 0, 0));
		send_frame(make_frame(S_MIN, S_MIN, 0, 0, 1, 0));
		send_frame(make_frame(32'h1234_5678, 32'h8765_4321, 1, 1, 0, 0));
		send_frame(make_frame(32'h0, 32'h0, 0, 0, 0, 1));

		drain();
		c.gravity     = S_MAX;
		c.inv_mass    = 24'hFF_FFFF;
		c.time_step   = 17'h1_FFFF;
		c.gnd_scale   = 17'h1_FFFF;
		c.air_scale   = 17'h1_FFFF;
		c.max_speed_x = 31'h7FFF_FFFF;
		c.max_speed_y = 31'h7FFF_FFFF;
		c.elasticity  = 17'h1_FFFF;
		apply_config(c);
		send_frame(make_frame(32'h0000_0100, 32'hFFFF_FF00, 0, 0, 0, 0));
		send_frame(make_frame(S_MIN, S_MIN, 1, 0, 0, 0));
		send_frame(make_frame(32'h0, 32'h0, 0, 1, 1, 0));	// bounce off saturated speed
		send_frame(make_frame(S_MAX, S_MAX, 1, 0, 0, 1));
		send_frame(make_frame(32'hFFFF_FFFF, 32'h0, 0, 1, 0, 0));
	endtask

	// Random frames over a run of settings: the all-low and all-high corners
	// first, then random settings; one phase runs with no idling at all.
	task automatic test_random_frames();
		cfg_t c;
		int   frames;
		for (int phase = 0; phase < 9; phase++) begin
			drain();
			if (phase == 0) begin
				c.gravity     = S_MIN;
				c.inv_mass    = 24'd1;
				c.time_step   = '0;
				c.gnd_scale   = '0;
				c.air_scale   = '0;
				c.max_speed_x = '0;
				c.max_speed_y = '0;
				c.elasticity  = '0;
			end else if (phase == 1) begin
				c.gravity     = S_MAX;
				c.inv_mass    = 24'hFF_FFFF;
				c.time_step   = 17'h1_0000;
				c.gnd_scale   = 17'h1_0000;
				c.air_scale   = 17'h1_0000;
				c.max_speed_x = 31'h7FFF_FFFF;
				c.max_speed_y = 31'h7FFF_FFFF;
				c.elasticity  = 17'h1_0000;
			end else begin
				c = random_setup();
			end
			apply_config(c);
			calm   = (phase == 4);
			frames = (phase < 2) ? 60 : 155;
			repeat (frames) send_frame(random_frame());
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		reset_predictor();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_bounce();
		test_edge_factors();
		test_random_frames();

		if (mismatch_count == 0 && frame_results_due.size() == 0) begin
			$display("point_mass_euler_integrator test passed");
		end else begin
			$display("point_mass_euler_integrator test failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/pme_pkg.sv
rtl/pme_cfg.sv
rtl/pme_ctrl.sv
rtl/pme_dp.sv
rtl/point_mass_euler_integrator.sv
rtl/pme_checker.sv
bench/tb_point_mass_euler_integrator.sv
